### hdl/afdx_pkg.sv
`timescale 1ns / 1ps

package afdx_pkg;

  // frame delimiter characters
  localparam logic [7:0] CH_OPEN  = 8'h3C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CLOSE = 8'h3E;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // length bounds
  localparam logic [7:0] LEN_MIN   = 8'd2;
  localparam logic [7:0] LEN_LIMIT = 8'd99;

  localparam logic [6:0] MAX_LEN_RESET = 7'd98;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BODY = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  // verdict error codes
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FRAME = 2'd1,
    ERR_CSUM  = 2'd2,
    ERR_LEN   = 2'd3
  } err_t;

  // receiver phases
  typedef enum logic [3:0] {
    PH_HUNT = 4'd0,
    PH_DEST = 4'd1,
    PH_C1   = 4'd2,
    PH_SRC  = 4'd3,
    PH_C2   = 4'd4,
    PH_LEN  = 4'd5,
    PH_C3   = 4'd6,
    PH_BODY = 4'd7,
    PH_C4   = 4'd8,
    PH_CK0  = 4'd9,
    PH_CK1  = 4'd10,
    PH_CK2  = 4'd11,
    PH_END  = 4'd12
  } phase_t;

  // one result item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] body_byte;
    logic [7:0] dest_id;
    logic [7:0] source_id;
    logic [7:0] frame_length;
    err_t       error_code;
  } result_t;

endpackage

### hdl/ascii_frame_deframer_xor.sv
`timescale 1ns / 1ps
// a result is registered and appears on out_ the cycle after the byte that causes it is transferred
// one byte per cycle while in_tready is high; the receiver state updates in a single pass per byte
// in_tready drops only while a result is held and out_tready is low
// reset (rst_n low, synchronous): receiver hunts for '<', header and checksum state cleared,
// no result pending, max_length returns to 98

module ascii_frame_deframer_xor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,   // max_length
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // rx_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,     // body_byte[7:0], dest_id[15:8], source_id[23:16],
                                     // frame_length[31:24], error_code[33:32], zero[39:34]
  output logic [1:0]  out_tuser      // kind[1:0]
);

  logic [6:0]        max_len_r;
  logic              take;
  logic              res_valid;
  logic              can_load;
  afdx_pkg::result_t res;
  afdx_pkg::result_t out_res;

  // max length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= afdx_pkg::MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  assign in_tready = can_load;
  assign take      = in_tvalid && can_load;

  afdx_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .max_length (max_len_r),
    .byte_take  (take),
    .rx_byte    (in_tdata),
    .res_valid  (res_valid),
    .res        (res)
  );

  afdx_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .res_valid (res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // pack result onto the stream
  assign out_tdata = {6'd0, out_res.error_code, out_res.frame_length, out_res.source_id,
                      out_res.dest_id, out_res.body_byte};
  assign out_tuser = out_res.kind;

endmodule

### hdl/afdx_parse.sv
`timescale 1ns / 1ps

module afdx_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [6:0]         max_length,
  input  logic               byte_take,
  input  logic [7:0]         rx_byte,
  output logic               res_valid,
  output afdx_pkg::result_t  res
);

  afdx_pkg::phase_t phase_r, phase_nxt;
  logic [6:0] pos_r, pos_nxt;
  logic [7:0] dest_r, dest_nxt;
  logic [7:0] src_r, src_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic       ck_bad_r, ck_bad_nxt;
  logic       xor_special;
  logic [6:0] pos_inc;
  logic       len_bad;

  assign xor_special = (xor_r == afdx_pkg::CH_COLON) || (xor_r == afdx_pkg::CH_CLOSE);
  assign pos_inc     = pos_r + 7'd1;
  assign len_bad     = (rx_byte < afdx_pkg::LEN_MIN) || (rx_byte > {1'b0, max_length})
                       || (rx_byte >= afdx_pkg::LEN_LIMIT);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= afdx_pkg::PH_HUNT;
      pos_r    <= '0;
      dest_r   <= '0;
      src_r    <= '0;
      len_r    <= '0;
      xor_r    <= '0;
      ck_bad_r <= 1'b0;
    end else if (byte_take) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      dest_r   <= dest_nxt;
      src_r    <= src_nxt;
      len_r    <= len_nxt;
      xor_r    <= xor_nxt;
      ck_bad_r <= ck_bad_nxt;
    end
  end

  // per-byte next state and result
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    dest_nxt   = dest_r;
    src_nxt    = src_r;
    len_nxt    = len_r;
    xor_nxt    = xor_r;
    ck_bad_nxt = ck_bad_r;
    res_valid  = 1'b0;
    res.kind         = afdx_pkg::KIND_BAD;
    res.body_byte    = '0;
    res.dest_id      = dest_r;
    res.source_id    = src_r;
    res.frame_length = len_r;
    res.error_code   = afdx_pkg::ERR_FRAME;
    case (phase_r)
      afdx_pkg::PH_HUNT: begin
        if (rx_byte == afdx_pkg::CH_OPEN) begin
          dest_nxt   = '0;
          src_nxt    = '0;
          len_nxt    = '0;
          xor_nxt    = '0;
          ck_bad_nxt = 1'b0;
          pos_nxt    = '0;
          phase_nxt  = afdx_pkg::PH_DEST;
        end
      end
      afdx_pkg::PH_DEST: begin
        if (rx_byte == 8'd0) begin
          res_valid = 1'b1;
          phase_nxt = afdx_pkg::PH_HUNT;
        end else begin
          dest_nxt  = rx_byte;
          xor_nxt   = xor_r ^ rx_byte;
          phase_nxt = afdx_pkg::PH_C1;
        end
      end
      afdx_pkg::PH_SRC: begin
        if (rx_byte == 8'd0) begin
          res_valid = 1'b1;
          phase_nxt = afdx_pkg::PH_HUNT;
        end else begin
          src_nxt   = rx_byte;
          xor_nxt   = xor_r ^ rx_byte;
          phase_nxt = afdx_pkg::PH_C2;
        end
      end
      afdx_pkg::PH_C1, afdx_pkg::PH_C2, afdx_pkg::PH_C3: begin
        if (rx_byte != afdx_pkg::CH_COLON) begin
          res_valid = 1'b1;
          phase_nxt = afdx_pkg::PH_HUNT;
        end else begin
          xor_nxt = xor_r ^ rx_byte;
          case (phase_r)
            afdx_pkg::PH_C1: phase_nxt = afdx_pkg::PH_SRC;
            afdx_pkg::PH_C2: phase_nxt = afdx_pkg::PH_LEN;
            default:         phase_nxt = afdx_pkg::PH_BODY;
          endcase
        end
      end
      afdx_pkg::PH_LEN: begin
        len_nxt = rx_byte;
        if (len_bad) begin
          res_valid        = 1'b1;
          res.frame_length = rx_byte;
          res.error_code   = afdx_pkg::ERR_LEN;
          phase_nxt        = afdx_pkg::PH_HUNT;
        end else begin
          xor_nxt   = xor_r ^ rx_byte;
          pos_nxt   = '0;
          phase_nxt = afdx_pkg::PH_C3;
        end
      end
      afdx_pkg::PH_BODY: begin
        xor_nxt = xor_r ^ rx_byte;
        pos_nxt = pos_inc;
        if ({1'b0, pos_inc} >= len_r) begin
          phase_nxt = afdx_pkg::PH_C4;
        end
        res_valid        = 1'b1;
        res.kind         = afdx_pkg::KIND_BODY;
        res.body_byte    = rx_byte;
        res.dest_id      = '0;
        res.source_id    = '0;
        res.frame_length = '0;
        res.error_code   = afdx_pkg::ERR_NONE;
      end
      afdx_pkg::PH_C4: begin
        if (rx_byte != afdx_pkg::CH_COLON) begin
          res_valid = 1'b1;
          phase_nxt = afdx_pkg::PH_HUNT;
        end else begin
          phase_nxt = afdx_pkg::PH_CK0;
        end
      end
      afdx_pkg::PH_CK0: begin
        if (rx_byte != (xor_special ? afdx_pkg::CH_ZERO : xor_r)) begin
          ck_bad_nxt = 1'b1;
        end
        phase_nxt = afdx_pkg::PH_CK1;
      end
      afdx_pkg::PH_CK1: begin
        if (rx_byte != afdx_pkg::CH_ZERO) begin
          ck_bad_nxt = 1'b1;
        end
        phase_nxt = afdx_pkg::PH_CK2;
      end
      afdx_pkg::PH_CK2: begin
        if (rx_byte != (xor_special ? xor_r : afdx_pkg::CH_ZERO)) begin
          ck_bad_nxt = 1'b1;
        end
        phase_nxt = afdx_pkg::PH_END;
      end
      afdx_pkg::PH_END: begin
        res_valid = 1'b1;
        phase_nxt = afdx_pkg::PH_HUNT;
        if (rx_byte != afdx_pkg::CH_CLOSE) begin
          res.error_code = afdx_pkg::ERR_FRAME;
        end else if (ck_bad_r) begin
          res.error_code = afdx_pkg::ERR_CSUM;
        end else begin
          res.kind       = afdx_pkg::KIND_GOOD;
          res.error_code = afdx_pkg::ERR_NONE;
        end
      end
      default: begin
        phase_nxt = afdx_pkg::PH_HUNT;
      end
    endcase
  end

endmodule

### hdl/afdx_out_reg.sv
`timescale 1ns / 1ps

module afdx_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic               res_valid,
  input  afdx_pkg::result_t  res,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output afdx_pkg::result_t  out_res
);

  logic              valid_r;
  afdx_pkg::result_t res_r;

  // slot frees when empty or drained this cycle
  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= res_valid;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

endmodule
